// ===== rtl/cpts_pkg.sv =====
// Package for the closest-points-between-two-segments unit.
// Payload word types, pipeline stage map, widths and the divider step helpers.
// No dependencies.
`default_nettype none

package cpts_pkg;

    // payload widths
    localparam int CW     = 32;            // Q16.16 coordinate
    localparam int FB     = 16;            // fraction bits of a parameter
    localparam int PW     = FB + 1;        // Q1.16 parameter
    localparam int LIM_W  = 16;            // parallel limit register
    localparam int THR_SH = 48;            // limit scale against |det|

    localparam logic [PW-1:0] ONE_Q16 = PW'(1) << FB;

    // datapath widths
    localparam int VW    = CW + 1;         // edge vectors
    localparam int PRW   = 2 * VW;         // one coordinate product
    localparam int DW    = PRW + 2;        // dot product, three terms
    localparam int LW    = 22;             // multiplier limb
    localparam int NL    = 3;              // limbs per magnitude
    localparam int MAGW  = NL * LW;        // dot product magnitude
    localparam int PPW   = 2 * LW;         // limb by limb product
    localparam int NG    = 2 * NL - 1;     // partial product weights
    localparam int GW    = PPW + 2;        // one weight group sum
    localparam int XW    = 2 * MAGW + 2;   // wide signed term
    localparam int RW    = XW + 1;         // divider remainder
    localparam int QPW   = PW + LW;        // parameter by limb product
    localparam int NPW   = VW + PW + 1;    // edge by parameter product
    localparam int NDOT  = 5;
    localparam int NMUL  = 4;
    localparam int NDIV  = 3;
    localparam int NREF  = 2;

    // stage map
    localparam int ST_IN    = 1;
    localparam int ST_DOT   = 2;
    localparam int ST_SUM   = 3;
    localparam int ST_PP    = 4;
    localparam int ST_GRP   = 5;
    localparam int ST_MAG   = 6;
    localparam int ST_NUM   = 7;
    localparam int ST_D0    = 8;
    localparam int RSTEP    = FB + 4;      // one refine: pp, mul, num, div init, steps
    localparam int ST_RPP   = ST_D0 + FB + 1;
    localparam int ST_NPP   = ST_D0 + NDIV * RSTEP - 3;
    localparam int NSTG     = ST_NPP + 1;

    typedef struct packed {
        logic signed [CW-1:0] a_start_x;
        logic signed [CW-1:0] a_start_y;
        logic signed [CW-1:0] a_start_z;
        logic signed [CW-1:0] a_end_x;
        logic signed [CW-1:0] a_end_y;
        logic signed [CW-1:0] a_end_z;
        logic signed [CW-1:0] b_start_x;
        logic signed [CW-1:0] b_start_y;
        logic signed [CW-1:0] b_start_z;
        logic signed [CW-1:0] b_end_x;
        logic signed [CW-1:0] b_end_y;
        logic signed [CW-1:0] b_end_z;
    } cpts_in_t;

    typedef struct packed {
        logic [PW-1:0]        param_a;
        logic [PW-1:0]        param_b;
        logic signed [CW-1:0] near_a_x;
        logic signed [CW-1:0] near_a_y;
        logic signed [CW-1:0] near_a_z;
        logic signed [CW-1:0] near_b_x;
        logic signed [CW-1:0] near_b_y;
        logic signed [CW-1:0] near_b_z;
    } cpts_out_t;

    // one restoring division in flight
    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] dvs;
        logic [FB-1:0] q;
        logic          zero;
        logic          sat;
    } div_t;

    function automatic logic [MAGW-1:0] mag_of(input logic [DW-1:0] x);
        logic [DW-1:0] m;
        m = x[DW-1] ? (~x + DW'(1)) : x;
        return m[MAGW-1:0];
    endfunction

    // zero when either side is not positive or forced, saturate when n >= d
    function automatic div_t div_init(input logic signed [XW-1:0] n,
                                      input logic signed [XW-1:0] d,
                                      input logic force_zero);
        div_t r;
        r.dvs  = {1'b0, d};
        r.zero = force_zero || d[XW-1] || (d == '0) || n[XW-1] || (n == '0);
        r.sat  = !r.zero && (n >= d);
        r.rem  = (r.zero || r.sat) ? '0 : {1'b0, n};
        r.q    = '0;
        return r;
    endfunction

    function automatic div_t div_step(input div_t x);
        div_t          r;
        logic [RW-1:0] sh;
        r  = x;
        sh = {x.rem[RW-2:0], 1'b0};
        if (sh >= x.dvs) begin
            r.rem = sh - x.dvs;
            r.q   = {x.q[FB-2:0], 1'b1};
        end else begin
            r.rem = sh;
            r.q   = {x.q[FB-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [PW-1:0] div_result(input div_t x);
        logic [PW-1:0] r;
        if (x.sat) begin
            r = ONE_Q16;
        end else if (x.zero) begin
            r = '0;
        end else begin
            r = {1'b0, x.q};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/closest_points_two_segments_unit.sv =====
// Closest points between two 3D segments, fully pipelined.
// Takes one word per cycle.
// busy is always low: a new pair may enter on every cycle, results leave in order.
// Reset (rst_n low, async) clears the valid chain and sets parallel_limit to 1.
// The depth is set by three back-to-back 16-step restoring divisions, one step a stage.
// Depends on cpts_pkg.
`default_nettype none

module closest_points_two_segments_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire cpts_pkg::cpts_in_t        operands,
    output logic                           done,
    output cpts_pkg::cpts_out_t            result,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [cpts_pkg::LIM_W-1:0] cfg_data
);

    // Data that rides along the whole pipe. Fields are filled at the stage
    // where they become known and are simply copied elsewhere.
    typedef struct packed {
        logic [2:0][cpts_pkg::CW-1:0] pa;   // segment A start
        logic [2:0][cpts_pkg::CW-1:0] pb;   // segment B start
        logic [2:0][cpts_pkg::VW-1:0] v1;   // A end - A start
        logic [2:0][cpts_pkg::VW-1:0] v2;   // B end - B start
        logic [2:0][cpts_pkg::VW-1:0] rv;   // A start - B start
        logic [cpts_pkg::DW-1:0]      da;   // v1.v1
        logic [cpts_pkg::DW-1:0]      db;   // v1.v2
        logic [cpts_pkg::DW-1:0]      dc;   // v2.v2
        logic [cpts_pkg::DW-1:0]      dd;   // v1.r
        logic [cpts_pkg::DW-1:0]      de;   // v2.r
        logic [cpts_pkg::PW-1:0]      s;
        logic [cpts_pkg::PW-1:0]      t;
    } side_t;

    // ------------------------------------------------------------------
    // Handshake and config
    // ------------------------------------------------------------------
    logic                       accept;
    logic [cpts_pkg::LIM_W-1:0] limit_reg, limit_next;

    assign busy      = 1'b0;       // no stall anywhere in the pipe
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_valid && cfg_ready) begin
            limit_next = cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic [cpts_pkg::NSTG:1] valid_reg, valid_next;

    side_t side_reg  [1:cpts_pkg::NSTG-1];
    side_t side_next [1:cpts_pkg::NSTG-1];

    logic signed [cpts_pkg::PRW-1:0] dot_reg  [0:cpts_pkg::NDOT-1][0:2];
    logic signed [cpts_pkg::PRW-1:0] dot_next [0:cpts_pkg::NDOT-1][0:2];

    logic [cpts_pkg::PPW-1:0] pp_reg  [0:cpts_pkg::NMUL-1][0:cpts_pkg::NL-1][0:cpts_pkg::NL-1];
    logic [cpts_pkg::PPW-1:0] pp_next [0:cpts_pkg::NMUL-1][0:cpts_pkg::NL-1][0:cpts_pkg::NL-1];
    logic [cpts_pkg::GW-1:0]  grp_reg  [0:cpts_pkg::NMUL-1][0:cpts_pkg::NG-1];
    logic [cpts_pkg::GW-1:0]  grp_next [0:cpts_pkg::NMUL-1][0:cpts_pkg::NG-1];
    logic [cpts_pkg::XW-1:0]  mag_reg  [0:cpts_pkg::NMUL-1];
    logic [cpts_pkg::XW-1:0]  mag_next [0:cpts_pkg::NMUL-1];
    logic [cpts_pkg::NMUL-1:0] mneg_reg  [0:2];   // product signs, stages PP..MAG
    logic [cpts_pkg::NMUL-1:0] mneg_next [0:2];

    logic signed [cpts_pkg::XW-1:0] negdet_reg, negdet_next;
    logic signed [cpts_pkg::XW-1:0] nums_reg, nums_next;

    cpts_pkg::div_t div_reg  [0:cpts_pkg::NDIV-1][0:cpts_pkg::FB];
    cpts_pkg::div_t div_next [0:cpts_pkg::NDIV-1][0:cpts_pkg::FB];

    logic [cpts_pkg::QPW-1:0]       qpp_reg  [0:cpts_pkg::NREF-1][0:cpts_pkg::NL-1];
    logic [cpts_pkg::QPW-1:0]       qpp_next [0:cpts_pkg::NREF-1][0:cpts_pkg::NL-1];
    logic [cpts_pkg::NREF-1:0]      qneg_reg, qneg_next;
    logic signed [cpts_pkg::XW-1:0] qb_reg   [0:cpts_pkg::NREF-1];
    logic signed [cpts_pkg::XW-1:0] qb_next  [0:cpts_pkg::NREF-1];
    logic signed [cpts_pkg::XW-1:0] num_reg  [0:cpts_pkg::NREF-1];
    logic signed [cpts_pkg::XW-1:0] num_next [0:cpts_pkg::NREF-1];
    logic signed [cpts_pkg::XW-1:0] den_reg  [0:cpts_pkg::NREF-1];
    logic signed [cpts_pkg::XW-1:0] den_next [0:cpts_pkg::NREF-1];

    logic signed [cpts_pkg::NPW-1:0] npa_reg [0:2], npa_next [0:2];
    logic signed [cpts_pkg::NPW-1:0] npb_reg [0:2], npb_next [0:2];

    cpts_pkg::cpts_out_t result_reg, result_next;

    assign valid_next = {valid_reg[cpts_pkg::NSTG-1:1], accept};

    // ------------------------------------------------------------------
    // Side pipe: input capture, dot sums, parameters as they settle
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [2:0][cpts_pkg::CW-1:0] ae;
        logic [2:0][cpts_pkg::CW-1:0] be;
        logic signed [cpts_pkg::DW-1:0] acc;

        ae = {operands.a_end_z, operands.a_end_y, operands.a_end_x};
        be = {operands.b_end_z, operands.b_end_y, operands.b_end_x};

        side_next[1]    = side_reg[1];
        side_next[1].pa = {operands.a_start_z, operands.a_start_y, operands.a_start_x};
        side_next[1].pb = {operands.b_start_z, operands.b_start_y, operands.b_start_x};
        for (int i = 0; i < 3; i++) begin
            side_next[1].v1[i] = {ae[i][cpts_pkg::CW-1], ae[i]}
                               - {side_next[1].pa[i][cpts_pkg::CW-1], side_next[1].pa[i]};
            side_next[1].v2[i] = {be[i][cpts_pkg::CW-1], be[i]}
                               - {side_next[1].pb[i][cpts_pkg::CW-1], side_next[1].pb[i]};
            side_next[1].rv[i] = {side_next[1].pa[i][cpts_pkg::CW-1], side_next[1].pa[i]}
                               - {side_next[1].pb[i][cpts_pkg::CW-1], side_next[1].pb[i]};
        end

        for (int k = 2; k < cpts_pkg::NSTG; k++) begin
            side_next[k] = side_reg[k-1];
        end

        // three-term dot sums
        for (int k = 0; k < cpts_pkg::NDOT; k++) begin
            acc = '0;
            for (int i = 0; i < 3; i++) begin
                acc = acc + cpts_pkg::DW'(dot_reg[k][i]);
            end
            case (k)
                0:       side_next[cpts_pkg::ST_SUM].da = acc;
                1:       side_next[cpts_pkg::ST_SUM].db = acc;
                2:       side_next[cpts_pkg::ST_SUM].dc = acc;
                3:       side_next[cpts_pkg::ST_SUM].dd = acc;
                default: side_next[cpts_pkg::ST_SUM].de = acc;
            endcase
        end

        side_next[cpts_pkg::ST_RPP + cpts_pkg::RSTEP].t =
            cpts_pkg::div_result(div_reg[1][cpts_pkg::FB]);
        side_next[cpts_pkg::ST_NPP].s = cpts_pkg::div_result(div_reg[2][cpts_pkg::FB]);
    end

    // ------------------------------------------------------------------
    // Dot products: one 33x33 multiplier per term
    // ------------------------------------------------------------------
    always_comb
    begin
        side_t sd;
        sd = side_reg[cpts_pkg::ST_DOT-1];
        for (int i = 0; i < 3; i++) begin
            dot_next[0][i] = $signed(sd.v1[i]) * $signed(sd.v1[i]);
            dot_next[1][i] = $signed(sd.v1[i]) * $signed(sd.v2[i]);
            dot_next[2][i] = $signed(sd.v2[i]) * $signed(sd.v2[i]);
            dot_next[3][i] = $signed(sd.v1[i]) * $signed(sd.rv[i]);
            dot_next[4][i] = $signed(sd.v2[i]) * $signed(sd.rv[i]);
        end
    end

    // ------------------------------------------------------------------
    // Wide products b*b, a*c, b*e, c*d: limb products, weight groups,
    // magnitude, then det and the s numerator
    // ------------------------------------------------------------------
    always_comb
    begin
        side_t                       sd;
        logic [cpts_pkg::DW-1:0]     opx [0:cpts_pkg::NMUL-1];
        logic [cpts_pkg::DW-1:0]     opy [0:cpts_pkg::NMUL-1];
        logic [cpts_pkg::MAGW-1:0]   xm;
        logic [cpts_pkg::MAGW-1:0]   ym;
        logic [cpts_pkg::XW-1:0]     acc;
        logic signed [cpts_pkg::XW-1:0] pbe;
        logic signed [cpts_pkg::XW-1:0] pcd;

        sd = side_reg[cpts_pkg::ST_PP-1];
        opx[0] = sd.db; opy[0] = sd.db;
        opx[1] = sd.da; opy[1] = sd.dc;
        opx[2] = sd.db; opy[2] = sd.de;
        opx[3] = sd.dc; opy[3] = sd.dd;

        for (int m = 0; m < cpts_pkg::NMUL; m++) begin
            xm = cpts_pkg::mag_of(opx[m]);
            ym = cpts_pkg::mag_of(opy[m]);
            mneg_next[0][m] = opx[m][cpts_pkg::DW-1] ^ opy[m][cpts_pkg::DW-1];
            for (int i = 0; i < cpts_pkg::NL; i++) begin
                for (int j = 0; j < cpts_pkg::NL; j++) begin
                    pp_next[m][i][j] = cpts_pkg::PPW'(xm[cpts_pkg::LW*i +: cpts_pkg::LW])
                                     * cpts_pkg::PPW'(ym[cpts_pkg::LW*j +: cpts_pkg::LW]);
                end
            end
        end
        mneg_next[1] = mneg_reg[0];
        mneg_next[2] = mneg_reg[1];

        for (int m = 0; m < cpts_pkg::NMUL; m++) begin
            for (int w = 0; w < cpts_pkg::NG; w++) begin
                grp_next[m][w] = '0;
                for (int i = 0; i < cpts_pkg::NL; i++) begin
                    for (int j = 0; j < cpts_pkg::NL; j++) begin
                        if (i + j == w) begin
                            grp_next[m][w] = grp_next[m][w] + cpts_pkg::GW'(pp_reg[m][i][j]);
                        end
                    end
                end
            end
        end

        for (int m = 0; m < cpts_pkg::NMUL; m++) begin
            acc = '0;
            for (int w = 0; w < cpts_pkg::NG; w++) begin
                acc = acc + (cpts_pkg::XW'(grp_reg[m][w]) << (cpts_pkg::LW * w));
            end
            mag_next[m] = acc;
        end

        // -det = a*c - b*b is never negative
        negdet_next = $signed(mag_reg[1] - mag_reg[0]);
        pbe = mneg_reg[2][2] ? -$signed(mag_reg[2]) : $signed(mag_reg[2]);
        pcd = mneg_reg[2][3] ? -$signed(mag_reg[3]) : $signed(mag_reg[3]);
        nums_next = pbe - pcd;
    end

    // ------------------------------------------------------------------
    // Dividers: three chains of 16 restoring steps. Chain 0 gives the
    // first s, chain 1 gives t, chain 2 gives the final s.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [cpts_pkg::XW-1:0] thr;
        thr = $signed({{(cpts_pkg::XW - cpts_pkg::LIM_W - cpts_pkg::THR_SH){1'b0}},
                       limit_reg, {cpts_pkg::THR_SH{1'b0}}});

        // parallel when |det| <= limit * 2^48: s starts at zero
        div_next[0][0] = cpts_pkg::div_init(nums_reg, negdet_reg, !(negdet_reg > thr));
        for (int u = 0; u < cpts_pkg::NREF; u++) begin
            div_next[u+1][0] = cpts_pkg::div_init(num_reg[u], den_reg[u], 1'b0);
        end
        for (int c = 0; c < cpts_pkg::NDIV; c++) begin
            for (int j = 1; j <= cpts_pkg::FB; j++) begin
                div_next[c][j] = cpts_pkg::div_step(div_reg[c][j-1]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Refine steps: q*b from three limb products, then the next numerator.
    //   u=0: t = (e*2^16 + s*b) / (c*2^16)
    //   u=1: s = (t*b - d*2^16) / (a*2^16)
    // Degenerate segments fall out of these: a zero divisor gives zero.
    // ------------------------------------------------------------------
    always_comb
    begin
        side_t                          sd;
        logic [cpts_pkg::PW-1:0]        q;
        logic [cpts_pkg::MAGW-1:0]      bm;
        logic [cpts_pkg::XW-1:0]        acc;
        logic signed [cpts_pkg::XW-1:0] ext;

        for (int u = 0; u < cpts_pkg::NREF; u++) begin
            sd = side_reg[cpts_pkg::ST_RPP + u*cpts_pkg::RSTEP - 1];
            q  = cpts_pkg::div_result(div_reg[u][cpts_pkg::FB]);
            bm = cpts_pkg::mag_of(sd.db);
            qneg_next[u] = sd.db[cpts_pkg::DW-1];
            for (int i = 0; i < cpts_pkg::NL; i++) begin
                qpp_next[u][i] = cpts_pkg::QPW'(q)
                               * cpts_pkg::QPW'(bm[cpts_pkg::LW*i +: cpts_pkg::LW]);
            end

            acc = '0;
            for (int i = 0; i < cpts_pkg::NL; i++) begin
                acc = acc + (cpts_pkg::XW'(qpp_reg[u][i]) << (cpts_pkg::LW * i));
            end
            qb_next[u] = qneg_reg[u] ? -$signed(acc) : $signed(acc);

            sd = side_reg[cpts_pkg::ST_RPP + u*cpts_pkg::RSTEP + 1];
            if (u == 0) begin
                ext         = $signed({{(cpts_pkg::XW - cpts_pkg::DW){sd.de[cpts_pkg::DW-1]}},
                                       sd.de});
                num_next[u] = (ext <<< cpts_pkg::FB) + qb_reg[u];
                den_next[u] = $signed({{(cpts_pkg::XW - cpts_pkg::DW){1'b0}}, sd.dc})
                              <<< cpts_pkg::FB;
            end else begin
                ext         = $signed({{(cpts_pkg::XW - cpts_pkg::DW){sd.dd[cpts_pkg::DW-1]}},
                                       sd.dd});
                num_next[u] = qb_reg[u] - (ext <<< cpts_pkg::FB);
                den_next[u] = $signed({{(cpts_pkg::XW - cpts_pkg::DW){1'b0}}, sd.da})
                              <<< cpts_pkg::FB;
            end
        end
    end

    // ------------------------------------------------------------------
    // Near points: start + floor(edge * param)
    // ------------------------------------------------------------------
    always_comb
    begin
        side_t                           sd;
        side_t                           so;
        logic signed [cpts_pkg::NPW-1:0] fa;
        logic signed [cpts_pkg::NPW-1:0] fb;
        logic [2:0][cpts_pkg::CW-1:0]    na;
        logic [2:0][cpts_pkg::CW-1:0]    nb;

        sd = side_reg[cpts_pkg::ST_NPP-1];
        for (int i = 0; i < 3; i++) begin
            npa_next[i] = $signed(sd.v1[i])
                        * $signed({1'b0, cpts_pkg::div_result(div_reg[2][cpts_pkg::FB])});
            npb_next[i] = $signed(sd.v2[i]) * $signed({1'b0, sd.t});
        end

        so = side_reg[cpts_pkg::NSTG-1];
        for (int i = 0; i < 3; i++) begin
            fa    = npa_reg[i] >>> cpts_pkg::FB;
            fb    = npb_reg[i] >>> cpts_pkg::FB;
            na[i] = so.pa[i] + fa[cpts_pkg::CW-1:0];
            nb[i] = so.pb[i] + fb[cpts_pkg::CW-1:0];
        end
        result_next.param_a  = so.s;
        result_next.param_b  = so.t;
        result_next.near_a_x = na[0];
        result_next.near_a_y = na[1];
        result_next.near_a_z = na[2];
        result_next.near_b_x = nb[0];
        result_next.near_b_y = nb[1];
        result_next.near_b_z = nb[2];
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            limit_reg <= cpts_pkg::LIM_W'(1);
        end else begin
            valid_reg <= valid_next;
            limit_reg <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg    <= side_next;
        dot_reg     <= dot_next;
        pp_reg      <= pp_next;
        grp_reg     <= grp_next;
        mag_reg     <= mag_next;
        mneg_reg    <= mneg_next;
        negdet_reg  <= negdet_next;
        nums_reg    <= nums_next;
        div_reg     <= div_next;
        qpp_reg     <= qpp_next;
        qneg_reg    <= qneg_next;
        qb_reg      <= qb_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        npa_reg     <= npa_next;
        npb_reg     <= npb_next;
        result_reg  <= result_next;
    end

    assign done   = valid_reg[cpts_pkg::NSTG];
    assign result = result_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.param_a <= cpts_pkg::ONE_Q16) && (result.param_b <= cpts_pkg::ONE_Q16))
        else $error("parameter outside [0,1]");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(cpts_pkg::NSTG) done)
        else $error("accepted word did not come out on time");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, cpts_pkg::NSTG))
        else $error("done without a matching accepted word");

endmodule

`default_nettype wire
